// ===== hw/rtl/backslash_escape_decoder_assert.svh =====
// Assertion helpers for the escape decoder.
// Both macros assume signals named clk and rst_n in the calling scope.
`ifndef BACKSLASH_ESCAPE_DECODER_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define BED_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BED_ASSERT_NOW(lbl, ante, cons)
`define BED_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/bed_pkg.sv =====
`timescale 1ns / 1ps

package bed_pkg;

    localparam int QUEUE_DEPTH = 4;

    // decoder modes
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_OCT  = 2'd3;

    localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;
    localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_V         = 8'h76;

    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    // one accepted item's worth of output: one or two bytes
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bed_front.sv =====
`timescale 1ns / 1ps

module bed_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_end,
    input  bed_pkg::q_status_t q_status,
    output logic               push,
    output bed_pkg::entry_t    push_entry
);

    logic [1:0] mode_reg, mode_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [8:0] acc_reg, acc_next;
    logic       emit0, emit1;
    logic [7:0] b0, b1;
    logic [4:0] hex;
    logic [1:0] cnt_inc;
    logic [7:0] run_value;
    logic       accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign hex      = bed_pkg::hex_digit(in_byte);
    assign cnt_inc  = cnt_reg + 2'd1;
    // value flushed by a run that ends early
    assign run_value = (mode_reg == bed_pkg::MODE_HEX && cnt_reg == 2'd0) ?
                       bed_pkg::CH_X : acc_reg[7:0];

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        emit0     = 1'b0;
        emit1     = 1'b0;
        b0        = in_byte;
        b1        = in_byte;
        if (in_end)
        begin
            mode_next = bed_pkg::MODE_TEXT;
            cnt_next  = 2'd0;
            acc_next  = 9'd0;
            unique case (mode_reg)
                bed_pkg::MODE_TEXT: emit0 = 1'b0;
                bed_pkg::MODE_ESC:
                begin
                    emit0 = 1'b1;
                    b0    = bed_pkg::CH_BACKSLASH;
                end
                default:
                begin
                    emit0 = 1'b1;
                    b0    = run_value;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                bed_pkg::MODE_TEXT:
                begin
                    if (in_byte == bed_pkg::CH_BACKSLASH)
                        mode_next = bed_pkg::MODE_ESC;
                    else
                        emit0 = 1'b1;
                end
                bed_pkg::MODE_ESC:
                begin
                    mode_next = bed_pkg::MODE_TEXT;
                    emit0     = 1'b1;
                    unique case (in_byte)
                        bed_pkg::CH_E: b0 = bed_pkg::CODE_ESC;
                        bed_pkg::CH_N: b0 = bed_pkg::CODE_LF;
                        bed_pkg::CH_T: b0 = bed_pkg::CODE_HT;
                        bed_pkg::CH_R: b0 = bed_pkg::CODE_CR;
                        bed_pkg::CH_A: b0 = bed_pkg::CODE_BEL;
                        bed_pkg::CH_B: b0 = bed_pkg::CODE_BS;
                        bed_pkg::CH_F: b0 = bed_pkg::CODE_FF;
                        bed_pkg::CH_V: b0 = bed_pkg::CODE_VT;
                        bed_pkg::CH_X:
                        begin
                            emit0     = 1'b0;
                            mode_next = bed_pkg::MODE_HEX;
                            cnt_next  = 2'd0;
                            acc_next  = 9'd0;
                        end
                        bed_pkg::CH_ZERO:
                        begin
                            emit0     = 1'b0;
                            mode_next = bed_pkg::MODE_OCT;
                            cnt_next  = 2'd0;
                            acc_next  = 9'd0;
                        end
                        default: b0 = in_byte;
                    endcase
                end
                default:
                begin
                    if (mode_reg == bed_pkg::MODE_HEX ? hex[4] : (in_byte[7:3] == 5'b00110))
                    begin
                        acc_next = (mode_reg == bed_pkg::MODE_HEX) ?
                                   {acc_reg[4:0], hex[3:0]} :
                                   {acc_reg[5:0], in_byte[2:0]};
                        cnt_next = cnt_inc;
                        if (cnt_inc >= ((mode_reg == bed_pkg::MODE_HEX) ?
                                        bed_pkg::HEX_DIGITS_MAX : bed_pkg::OCT_DIGITS_MAX))
                        begin
                            emit0     = 1'b1;
                            b0        = acc_next[7:0];
                            mode_next = bed_pkg::MODE_TEXT;
                            cnt_next  = 2'd0;
                            acc_next  = 9'd0;
                        end
                    end
                    else
                    begin
                        // flush the run, then treat the byte as plain text
                        emit0     = 1'b1;
                        b0        = run_value;
                        cnt_next  = 2'd0;
                        acc_next  = 9'd0;
                        if (in_byte == bed_pkg::CH_BACKSLASH)
                        begin
                            mode_next = bed_pkg::MODE_ESC;
                        end
                        else
                        begin
                            mode_next = bed_pkg::MODE_TEXT;
                            emit1     = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign push            = accept && emit0;
    assign push_entry.two  = emit1;
    assign push_entry.b0   = b0;
    assign push_entry.b1   = b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bed_pkg::MODE_TEXT;
            cnt_reg  <= 2'd0;
            acc_reg  <= 9'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// ===== hw/rtl/bed_queue.sv =====
`timescale 1ns / 1ps

module bed_queue
#(
    parameter int DEPTH = bed_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bed_pkg::entry_t    push_entry,
    input  logic               pop,
    output bed_pkg::q_status_t status,
    output bed_pkg::entry_t    head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bed_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign head         = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/bed_back.sv =====
`timescale 1ns / 1ps

module bed_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  bed_pkg::q_status_t q_status,
    input  bed_pkg::entry_t    head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    // set while the second byte of a two-byte entry is due
    logic second_reg;

    assign out_valid = q_status.valid;
    assign out_byte  = second_reg ? head.b1 : head.b0;
    assign out_last  = !head.two || second_reg;
    assign pop       = out_valid && out_ready && out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else if (out_valid && out_ready)
            second_reg <= !out_last;
    end

endmodule

// ===== hw/rtl/backslash_escape_decoder.sv =====
`timescale 1ns / 1ps
// Backslash escape decoder.
// Slave stream: one text byte per word in s_tdata; s_tlast high marks the
// end of the text, carries no byte and flushes any pending escape.
// Master stream: one decoded byte per word in m_tdata; m_tlast is high on
// the last word caused by a given input word.
// An accepted word's output passes through one queue register before it
// reaches the master stream.
// Throughput: one input word per cycle while the queue has room. Most
// words give zero or one output word; a word that ends a hex or octal run
// may give two, which the back end sends one after the other as m_tready
// allows. The front end classifies the word and updates the escape state
// in the accepting cycle; the result goes into a QUEUE_DEPTH-entry queue,
// so s_tready only drops while that queue is full, which only a stalled
// receiver causes (a two-byte word always comes after two input words that
// give no output). When m_tready is low the current word holds and the
// queue fills; input is taken until it is full.
// Reset (rst_n low, asynchronous) returns to plain text mode and empties
// the queue.
`include "backslash_escape_decoder_assert.svh"

module backslash_escape_decoder
#(
    parameter int QUEUE_DEPTH = bed_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // end_marker
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_of_run
);

    bed_pkg::q_status_t q_status;
    bed_pkg::entry_t    push_entry;
    bed_pkg::entry_t    head;
    logic               push;
    logic               pop;

    bed_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    bed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .status     (q_status),
        .head       (head)
    );

    bed_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

    `BED_ASSERT_NEXT(a_push_lands, push && push_entry.two, m_tvalid)
    `BED_ASSERT_NEXT(a_second_follows, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)
    `BED_ASSERT_NOW(a_stall_means_backlog, !s_tready, m_tvalid)
    `BED_ASSERT_NOW(a_push_only_on_accept, push, s_tvalid && s_tready)

endmodule
